// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off during rst
`define MVW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MVW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mvw_pkg.sv -----
// ---------------------------------------------------------------------------
// mvw_pkg
// Types and constants of the vertex weld and face cull block.
// ---------------------------------------------------------------------------
package mvw_pkg;

  localparam int TABLE_DEPTH_DEF   = 4096;
  localparam int MESH_VERTICES_DEF = 4096;
  localparam int COORD_FRAC_DEF    = 8;

  localparam int INDEX_LIMIT = 4096;
  localparam int IDX_W       = 12;
  localparam int SCALE_FRAC  = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_WELD_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_AREA   = 2'd1;

  localparam logic [31:0] WELD_SCALE_RST = 32'd65536;

  localparam logic [2:0] RSN_KEPT   = 3'd0;
  localparam logic [2:0] RSN_COUNT  = 3'd1;
  localparam logic [2:0] RSN_UNSEEN = 3'd2;
  localparam logic [2:0] RSN_REPEAT = 3'd3;
  localparam logic [2:0] RSN_AREA   = 3'd4;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_MUL_END,
    S_Q_SETUP,
    S_Q_RND,
    S_HASH,
    S_HASH_MOD,
    S_PROBE_RD,
    S_PROBE_CHK,
    S_V_NEW,
    S_F_ALIAS_RD,
    S_F_ALIAS_CHK,
    S_F_DUP,
    S_F_KEPT_RD,
    S_F_KEPT_CHK,
    S_F_PM,
    S_F_QM,
    S_F_SQ,
    S_F_SUM,
    S_F_THR,
    S_F_CMP,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic             used;
    logic [IDX_W-1:0] index;
    logic [31:0]      kx;
    logic [31:0]      ky;
    logic [31:0]      kz;
  } cell_row_t;

endpackage

// ----- rtl/mvw_ram.sv -----
// ---------------------------------------------------------------------------
// mvw_ram
// Single-port-write, single-port-read RAM with registered read data.
// ---------------------------------------------------------------------------
module mvw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/mesh_vertex_weld_and_face_cull.sv -----
// ---------------------------------------------------------------------------
// mesh_vertex_weld_and_face_cull
// Welds vertices into grid cells through a linear-probing hash table and
// culls faces with a bad corner count or with unseen, repeated or degenerate corners.
//
//   channel  handshake            payload
//   input    start / busy         func, mesh_vertex, coord_*, corner_*
//   result   done (strobe)        compact_index .. reject_reason
//   config   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// After reset a clearing pass over max(TABLE_DEPTH, MESH_VERTICES) entries
// runs with busy high. All products but the hash multiply-back go through
// one 32x32 multiplier stepped over 3x3 limbs; the hash remainder is a
// reciprocal product and one compare-subtract. A vertex word keeps busy
// high while it quantizes, hashes and probes, and opening a cell adds one
// state; a face word with a bad corner count goes straight to the result.
// The result shows on done for one cycle; the receiver cannot stall.
// ---------------------------------------------------------------------------
module mesh_vertex_weld_and_face_cull
  import mvw_pkg::*;
#(
  parameter int TABLE_DEPTH     = TABLE_DEPTH_DEF,
  parameter int MESH_VERTICES   = MESH_VERTICES_DEF,
  parameter int COORD_FRAC_BITS = COORD_FRAC_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  func,
  input  logic [11:0]           mesh_vertex,
  input  logic signed [31:0]    coord_x,
  input  logic signed [31:0]    coord_y,
  input  logic signed [31:0]    coord_z,
  input  logic [3:0]            corner_count,
  input  logic [11:0]           corner_a,
  input  logic [11:0]           corner_b,
  input  logic [11:0]           corner_c,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  done,
  output logic [11:0]           compact_index,
  output logic                  is_new,
  output logic                  table_full,
  output logic                  face_kept,
  output logic [11:0]           tri_a,
  output logic [11:0]           tri_b,
  output logic [11:0]           tri_c,
  output logic [2:0]            reject_reason
);

  localparam int SW    = $clog2(TABLE_DEPTH);
  localparam int MW    = $clog2(MESH_VERTICES);
  localparam int CLR_N = (TABLE_DEPTH > MESH_VERTICES) ? TABLE_DEPTH : MESH_VERTICES;
  localparam int CLRW  = $clog2(CLR_N);
  localparam int SH    = COORD_FRAC_BITS + SCALE_FRAC;
  localparam int AREA_SH = 4 * COORD_FRAC_BITS;
  localparam int CW    = 168;
  localparam int ROW_W = $bits(cell_row_t);
  localparam logic [63:0] HASH_RECIP = 64'((65'd1 << 64) / 65'(TABLE_DEPTH));

  state_t state, state_next, ret;

  logic [CLRW-1:0] clr;
  logic [31:0]     weld_scale;
  logic [47:0]     min_area;
  logic [12:0]     next_index;

  logic [11:0]     in_mv;
  logic [31:0]     in_coord [3];
  logic [11:0]     in_corner [3];
  logic [1:0]      cnt;
  logic [1:0]      comp;

  logic [95:0]     mul_x, mul_y;
  logic [1:0]      mi, mj;
  logic [63:0]     prod;
  logic [2:0]      pk;
  logic            pv;
  logic [191:0]    acc;

  logic [31:0]     key [3];
  logic [SW-1:0]   slot;
  logic [SW-1:0]   probes;

  logic [11:0]     ids [3];
  logic [31:0]     p0 [3];
  logic [32:0]     u [3];
  logic [32:0]     v [3];
  logic [63:0]     pm;
  logic [131:0]    sum;

  // memories
  logic            cell_we;
  logic [SW-1:0]   cell_waddr;
  cell_row_t       cell_wrow, row;
  logic [ROW_W-1:0] cell_rdata;
  logic            kept_we;
  logic [95:0]     kept_rdata;
  logic            alias_we;
  logic [MW-1:0]   alias_waddr;
  logic [12:0]     alias_wdata;
  logic [12:0]     alias_rdata;

  // combinational helpers
  logic [31:0]     mul_a, mul_b;
  logic [31:0]     q_src, q_mag, q_key;
  logic [64:0]     q_sum, q_val;
  logic [31:0]     hv;
  logic [31:0]     hq;
  logic [48:0]     hprod;
  logic [32:0]     hr;
  logic [SW-1:0]   rem_next;
  logic            key_hit, idx_free, mv_ok, corner_ok, dup, last_probe;
  logic [32:0]     op_a, op_b, op_c, op_d;
  logic [31:0]     mag_a, mag_b, mag_c, mag_d;
  logic            sg_pm, sg_qm;
  logic [64:0]     m_val;
  logic [CW-1:0]   lhs, rhs;
  logic [32:0]     row_c [3];

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign row       = cell_row_t'(cell_rdata);

  // one shared multiplier, limb select
  assign mul_a = mul_x[{mi, 5'b0} +: 32];
  assign mul_b = mul_y[{mj, 5'b0} +: 32];

  // quantize
  always_comb begin
    q_src = in_coord[cnt];
    q_mag = q_src[31] ? (32'd0 - q_src) : q_src;
    q_sum = {1'b0, acc[63:0]} + (65'd1 << (SH - 1));
    q_val = q_sum >> SH;
    if (!q_src[31]) begin
      q_key = (q_val > 65'h7FFF_FFFF) ? 32'h7FFF_FFFF : q_val[31:0];
    end else begin
      q_key = (q_val > 65'h8000_0000) ? 32'h8000_0000 : (32'd0 - q_val[31:0]);
    end
  end

  // hash remainder: reciprocal quotient is low by at most one
  assign hv       = key[0] ^ (key[1] << 1) ^ (key[2] << 2);
  assign hq       = acc[95:64];
  assign hprod    = 49'(hq) * 49'(TABLE_DEPTH);
  assign hr       = {1'b0, hv} - hprod[32:0];
  assign rem_next = (hr >= 33'(TABLE_DEPTH)) ? SW'(hr - 33'(TABLE_DEPTH)) : SW'(hr);

  assign key_hit    = (row.kx == key[0]) && (row.ky == key[1]) && (row.kz == key[2]);
  assign idx_free   = (next_index < 13'(INDEX_LIMIT));
  assign mv_ok      = (32'(in_mv) < MESH_VERTICES);
  assign corner_ok  = (32'(in_corner[cnt]) < MESH_VERTICES);
  assign dup        = (ids[0] == ids[1]) || (ids[1] == ids[2]) || (ids[0] == ids[2]);
  assign last_probe = (probes == SW'(TABLE_DEPTH - 1));

  // cross product operand select: (a*b - c*d)
  always_comb begin
    case (comp)
      2'd0: begin
        op_a = u[1]; op_b = v[2]; op_c = u[2]; op_d = v[1];
      end
      2'd1: begin
        op_a = u[2]; op_b = v[0]; op_c = u[0]; op_d = v[2];
      end
      default: begin
        op_a = u[0]; op_b = v[1]; op_c = u[1]; op_d = v[0];
      end
    endcase
    mag_a = op_a[32] ? 32'(33'd0 - op_a) : op_a[31:0];
    mag_b = op_b[32] ? 32'(33'd0 - op_b) : op_b[31:0];
    mag_c = op_c[32] ? 32'(33'd0 - op_c) : op_c[31:0];
    mag_d = op_d[32] ? 32'(33'd0 - op_d) : op_d[31:0];
    sg_pm = op_a[32] ^ op_b[32];
    sg_qm = op_c[32] ^ op_d[32];
    if (sg_pm != sg_qm) begin
      m_val = {1'b0, pm} + {1'b0, acc[63:0]};
    end else if (pm >= acc[63:0]) begin
      m_val = {1'b0, pm - acc[63:0]};
    end else begin
      m_val = {1'b0, acc[63:0] - pm};
    end
  end

  assign lhs = CW'({sum, 32'b0});
  assign rhs = CW'({acc[95:0], 2'b00}) << AREA_SH;

  always_comb begin
    row_c[0] = {kept_rdata[95], kept_rdata[95:64]};
    row_c[1] = {kept_rdata[63], kept_rdata[63:32]};
    row_c[2] = {kept_rdata[31], kept_rdata[31:0]};
  end

  // memory ports
  always_comb begin
    cell_we    = 1'b0;
    cell_waddr = slot;
    cell_wrow  = '{used: 1'b1, index: next_index[IDX_W-1:0],
                   kx: key[0], ky: key[1], kz: key[2]};
    if (state == S_CLEAR) begin
      cell_we    = ({1'b0, clr} < (CLRW+1)'(TABLE_DEPTH));
      cell_waddr = SW'(clr);
      cell_wrow  = '0;
    end else if (state == S_V_NEW) begin
      cell_we = 1'b1;
    end
  end

  always_comb begin
    alias_we    = 1'b0;
    alias_waddr = MW'(in_mv);
    alias_wdata = {1'b1, next_index[IDX_W-1:0]};
    if (state == S_CLEAR) begin
      alias_we    = ({1'b0, clr} < (CLRW+1)'(MESH_VERTICES));
      alias_waddr = MW'(clr);
      alias_wdata = '0;
    end else if (state == S_V_NEW) begin
      alias_we = mv_ok;
    end else if (state == S_PROBE_CHK && row.used && key_hit) begin
      alias_we    = mv_ok;
      alias_wdata = {1'b1, row.index};
    end
  end

  assign kept_we = (state == S_V_NEW);

  mvw_ram #(.WIDTH(ROW_W), .DEPTH(TABLE_DEPTH)) u_cell (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (ROW_W'(cell_wrow)),
    .raddr (slot),
    .rdata (cell_rdata)
  );

  mvw_ram #(.WIDTH(96), .DEPTH(INDEX_LIMIT)) u_kept (
    .clk   (clk),
    .we    (kept_we),
    .waddr (next_index[IDX_W-1:0]),
    .wdata ({in_coord[0], in_coord[1], in_coord[2]}),
    .raddr (ids[cnt]),
    .rdata (kept_rdata)
  );

  mvw_ram #(.WIDTH(13), .DEPTH(MESH_VERTICES)) u_alias (
    .clk   (clk),
    .we    (alias_we),
    .waddr (alias_waddr),
    .wdata (alias_wdata),
    .raddr (MW'(in_corner[cnt])),
    .rdata (alias_rdata)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr == CLRW'(CLR_N - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (!func) state_next = S_Q_SETUP;
          else if (corner_count != 4'd3) state_next = S_FINISH;
          else state_next = S_F_ALIAS_RD;
        end
      end
      S_MUL: begin
        if (mi == 2'd2 && mj == 2'd2) state_next = S_MUL_END;
      end
      S_MUL_END: state_next = ret;
      S_Q_SETUP, S_HASH, S_F_PM, S_F_QM, S_F_SQ, S_F_THR: state_next = S_MUL;
      S_Q_RND: state_next = (cnt == 2'd2) ? S_HASH : S_Q_SETUP;
      S_HASH_MOD: state_next = S_PROBE_RD;
      S_PROBE_RD: state_next = S_PROBE_CHK;
      S_PROBE_CHK: begin
        if (!row.used) state_next = idx_free ? S_V_NEW : S_FINISH;
        else if (key_hit || last_probe) state_next = S_FINISH;
        else state_next = S_PROBE_RD;
      end
      S_V_NEW: state_next = S_FINISH;
      S_F_ALIAS_RD: state_next = S_F_ALIAS_CHK;
      S_F_ALIAS_CHK: begin
        if (!corner_ok || !alias_rdata[12]) state_next = S_FINISH;
        else if (cnt == 2'd2) state_next = S_F_DUP;
        else state_next = S_F_ALIAS_RD;
      end
      S_F_DUP: state_next = dup ? S_FINISH : S_F_KEPT_RD;
      S_F_KEPT_RD: state_next = S_F_KEPT_CHK;
      S_F_KEPT_CHK: state_next = (cnt == 2'd2) ? S_F_PM : S_F_KEPT_RD;
      S_F_SUM: state_next = (comp == 2'd2) ? S_F_THR : S_F_PM;
      S_F_CMP: state_next = S_FINISH;
      S_FINISH: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr        <= '0;
      next_index <= '0;
      weld_scale <= WELD_SCALE_RST;
      min_area   <= '0;
      done       <= 1'b0;
      pv         <= 1'b0;
    end else begin
      done <= (state == S_FINISH);
      pv   <= (state == S_MUL);
      if (state == S_CLEAR) clr <= clr + 1'b1;
      if (state == S_V_NEW) next_index <= next_index + 13'd1;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WELD_SCALE: weld_scale <= cfg_data[31:0];
          CFG_MIN_AREA:   min_area   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    pk   <= {1'b0, mi} + {1'b0, mj};
    if (pv) begin
      acc <= acc + ({128'b0, prod} << {pk, 5'b0});
    end
    case (state)
      S_IDLE: begin
        if (start) begin
          in_mv         <= mesh_vertex;
          in_coord[0]   <= coord_x;
          in_coord[1]   <= coord_y;
          in_coord[2]   <= coord_z;
          in_corner[0]  <= corner_a;
          in_corner[1]  <= corner_b;
          in_corner[2]  <= corner_c;
          cnt           <= 2'd0;
          compact_index <= '0;
          is_new        <= 1'b0;
          table_full    <= 1'b0;
          face_kept     <= 1'b0;
          tri_a         <= '0;
          tri_b         <= '0;
          tri_c         <= '0;
          reject_reason <= (func && corner_count != 4'd3) ? RSN_COUNT : RSN_KEPT;
        end
      end
      S_MUL: begin
        if (mj == 2'd2) begin
          mj <= 2'd0;
          mi <= mi + 2'd1;
        end else begin
          mj <= mj + 2'd1;
        end
      end
      S_Q_SETUP: begin
        mul_x <= {64'b0, q_mag};
        mul_y <= {64'b0, weld_scale};
        acc   <= '0;
        mi    <= '0;
        mj    <= '0;
        ret   <= S_Q_RND;
      end
      S_Q_RND: begin
        key[cnt] <= q_key;
        cnt      <= cnt + 2'd1;
      end
      S_HASH: begin
        mul_x <= {64'b0, hv};
        mul_y <= {32'b0, HASH_RECIP};
        acc   <= '0;
        mi    <= '0;
        mj    <= '0;
        ret   <= S_HASH_MOD;
      end
      S_HASH_MOD: begin
        slot   <= rem_next;
        probes <= '0;
      end
      S_PROBE_CHK: begin
        if (!row.used) begin
          if (!idx_free) table_full <= 1'b1;
        end else if (key_hit) begin
          compact_index <= row.index;
        end else if (last_probe) begin
          table_full <= 1'b1;
        end else begin
          probes <= probes + 1'b1;
          slot   <= (slot == SW'(TABLE_DEPTH - 1)) ? '0 : slot + 1'b1;
        end
      end
      S_V_NEW: begin
        compact_index <= next_index[IDX_W-1:0];
        is_new        <= 1'b1;
      end
      S_F_ALIAS_CHK: begin
        if (!corner_ok || !alias_rdata[12]) begin
          reject_reason <= RSN_UNSEEN;
        end else begin
          ids[cnt] <= alias_rdata[11:0];
          cnt      <= (cnt == 2'd2) ? 2'd0 : cnt + 2'd1;
        end
      end
      S_F_DUP: begin
        if (dup) reject_reason <= RSN_REPEAT;
      end
      S_F_KEPT_CHK: begin
        case (cnt)
          2'd0: begin
            p0[0] <= kept_rdata[95:64];
            p0[1] <= kept_rdata[63:32];
            p0[2] <= kept_rdata[31:0];
          end
          2'd1: begin
            u[0] <= row_c[0] - {p0[0][31], p0[0]};
            u[1] <= row_c[1] - {p0[1][31], p0[1]};
            u[2] <= row_c[2] - {p0[2][31], p0[2]};
          end
          default: begin
            v[0] <= row_c[0] - {p0[0][31], p0[0]};
            v[1] <= row_c[1] - {p0[1][31], p0[1]};
            v[2] <= row_c[2] - {p0[2][31], p0[2]};
          end
        endcase
        cnt  <= cnt + 2'd1;
        comp <= 2'd0;
        sum  <= '0;
      end
      S_F_PM: begin
        mul_x <= {64'b0, mag_a};
        mul_y <= {64'b0, mag_b};
        acc   <= '0;
        mi    <= '0;
        mj    <= '0;
        ret   <= S_F_QM;
      end
      S_F_QM: begin
        pm    <= acc[63:0];
        mul_x <= {64'b0, mag_c};
        mul_y <= {64'b0, mag_d};
        acc   <= '0;
        mi    <= '0;
        mj    <= '0;
        ret   <= S_F_SQ;
      end
      S_F_SQ: begin
        mul_x <= {31'b0, m_val};
        mul_y <= {31'b0, m_val};
        acc   <= '0;
        mi    <= '0;
        mj    <= '0;
        ret   <= S_F_SUM;
      end
      S_F_SUM: begin
        sum  <= sum + acc[131:0];
        comp <= comp + 2'd1;
      end
      S_F_THR: begin
        mul_x <= {48'b0, min_area};
        mul_y <= {48'b0, min_area};
        acc   <= '0;
        mi    <= '0;
        mj    <= '0;
        ret   <= S_F_CMP;
      end
      S_F_CMP: begin
        if (lhs >= rhs) begin
          face_kept <= 1'b1;
          tri_a     <= ids[0];
          tri_b     <= ids[1];
          tri_c     <= ids[2];
        end else begin
          reject_reason <= RSN_AREA;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/mvw_checker.sv -----
// ---------------------------------------------------------------------------
// mvw_checker
// Port-level checks of the weld and cull block, bound to its top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mvw_checker
  import mvw_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        is_new,
  input logic        table_full,
  input logic        face_kept,
  input logic [11:0] tri_a,
  input logic [11:0] tri_b,
  input logic [11:0] tri_c,
  input logic [2:0]  reject_reason
);

  `MVW_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
  `MVW_ASSERT_SAME(a_done_idle, done, !busy, "result strobe while busy")
  `MVW_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
  `MVW_ASSERT_SAME(a_kept_clean, done && face_kept, reject_reason == RSN_KEPT && tri_a != tri_b && tri_b != tri_c && tri_a != tri_c, "kept face with reason or repeated corners")
  `MVW_ASSERT_SAME(a_new_flags, done && is_new, !table_full && !face_kept, "new vertex with conflicting flags")

endmodule

bind mesh_vertex_weld_and_face_cull mvw_checker u_mvw_checker (.*);

// ----- test/tb_mesh_vertex_weld_and_face_cull.sv -----
// ----------------------------------------------------------------------------
// tb_mesh_vertex_weld_and_face_cull
// Checks vertex welding and face culling against a built-in predictor.
// A short directed run covers the coordinate extremes, aliasing, remapping
// and every face reject reason. Random phases follow, each under its own
// weld scale and area threshold; the sender idle rate varies across them. Every
// result word is compared field by field with the predicted one.
// ----------------------------------------------------------------------------
module tb_mesh_vertex_weld_and_face_cull;
  import mvw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic FN_VERTEX = 1'b0;
  localparam logic FN_FACE   = 1'b1;

  typedef struct {
    logic        fn;
    logic [11:0] mv;
    logic [31:0] x, y, z;
    logic [3:0]  cnt;
    logic [11:0] ca, cb, cc;
  } word_t;

  typedef struct {
    logic [11:0] ci;
    logic        nw, full, kept;
    logic [11:0] ta, tb, tc;
    logic [2:0]  rsn;
  } weld_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic func = 1'b0;
  logic [11:0] mesh_vertex = '0;
  logic signed [31:0] coord_x = '0, coord_y = '0, coord_z = '0;
  logic [3:0] corner_count = '0;
  logic [11:0] corner_a = '0, corner_b = '0, corner_c = '0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic busy, cfg_ready, done, is_new, table_full, face_kept;
  logic [11:0] compact_index, tri_a, tri_b, tri_c;
  logic [2:0] reject_reason;

  mesh_vertex_weld_and_face_cull i_dut (.*);

  // predictor state
  bit [31:0] key_x[4096], key_y[4096], key_z[4096];
  bit        slot_used[4096];
  bit [11:0] slot_index[4096];
  bit [31:0] pos_x[4096], pos_y[4096], pos_z[4096];
  bit [12:0] alias_tab[4096];
  int        pred_index = 0;
  bit [31:0] weld_scale = WELD_SCALE_RST;
  bit [47:0] min_area = '0;

  word_t     pending[$];
  weld_res_t expected[$];
  word_t     on_bus;
  int        idle_pct = 0;
  int        fails = 0;
  logic [11:0] recent_mv[$];

  function automatic bit [31:0] cell_coord(bit [31:0] raw);
    bit        neg;
    bit [31:0] nr;
    bit [64:0] p, q;
    neg = raw[31];
    nr = 32'd0 - raw;
    p = (neg ? nr : raw) * {33'd0, weld_scale};
    q = (p + 65'h800000) >> 24;
    if (!neg) return (q > 65'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
    if (q > 65'h80000000) q = 65'h80000000;
    return 32'd0 - q[31:0];
  endfunction

  function automatic bit area_passes(int i0, int i1, int i2);
    logic signed [159:0] ux, uy, uz, vx, vy, vz, cx, cy, cz, m, t;
    ux = longint'($signed(pos_x[i1])) - longint'($signed(pos_x[i0]));
    uy = longint'($signed(pos_y[i1])) - longint'($signed(pos_y[i0]));
    uz = longint'($signed(pos_z[i1])) - longint'($signed(pos_z[i0]));
    vx = longint'($signed(pos_x[i2])) - longint'($signed(pos_x[i0]));
    vy = longint'($signed(pos_y[i2])) - longint'($signed(pos_y[i0]));
    vz = longint'($signed(pos_z[i2])) - longint'($signed(pos_z[i0]));
    cx = uy * vz - uz * vy;
    cy = uz * vx - ux * vz;
    cz = ux * vy - uy * vx;
    m = cx * cx + cy * cy + cz * cz;
    t = min_area;
    t = 4 * t * t;
    return m >= t;
  endfunction

  function automatic weld_res_t weld_predict(word_t w);
    weld_res_t r;
    bit [31:0] kx, ky, kz, hx;
    bit [11:0] ids[3], cn[3];
    int slot, idx;
    bit found, free;
    r = '{default: '0};
    found = 0;
    free = 0;
    slot = 0;
    if (w.fn == FN_VERTEX) begin
      kx = cell_coord(w.x);
      ky = cell_coord(w.y);
      kz = cell_coord(w.z);
      hx = kx ^ (ky << 1) ^ (kz << 2);
      for (int i = 0; i < 4096; i++) begin
        slot = (hx[11:0] + i) % 4096;
        if (!slot_used[slot]) begin
          free = 1;
          break;
        end
        if (key_x[slot] == kx && key_y[slot] == ky && key_z[slot] == kz) begin
          found = 1;
          break;
        end
      end
      if (found) idx = int'(slot_index[slot]);
      else if (free && pred_index < INDEX_LIMIT) begin
        idx = pred_index++;
        slot_used[slot] = 1;
        key_x[slot] = kx;
        key_y[slot] = ky;
        key_z[slot] = kz;
        slot_index[slot] = 12'(idx);
        pos_x[idx] = w.x;
        pos_y[idx] = w.y;
        pos_z[idx] = w.z;
        r.nw = 1;
      end else begin
        r.full = 1;
        return r;
      end
      r.ci = 12'(idx);
      alias_tab[w.mv] = {1'b1, 12'(idx)};
      return r;
    end
    if (w.cnt != 4'd3) begin
      r.rsn = RSN_COUNT;
      return r;
    end
    cn = '{w.ca, w.cb, w.cc};
    foreach (cn[k]) begin
      if (!alias_tab[cn[k]][12]) begin
        r.rsn = RSN_UNSEEN;
        return r;
      end
      ids[k] = alias_tab[cn[k]][11:0];
    end
    if (ids[0] == ids[1] || ids[1] == ids[2] || ids[0] == ids[2]) begin
      r.rsn = RSN_REPEAT;
      return r;
    end
    if (!area_passes(ids[0], ids[1], ids[2])) begin
      r.rsn = RSN_AREA;
      return r;
    end
    r.kept = 1;
    r.ta = ids[0];
    r.tb = ids[1];
    r.tc = ids[2];
    r.rsn = RSN_KEPT;
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    fails++;
  endtask

  task automatic add_vertex(logic [11:0] mv, logic [31:0] x, y, z);
    word_t w;
    w = '{default: '0};
    w.fn = FN_VERTEX;
    w.mv = mv;
    w.x = x;
    w.y = y;
    w.z = z;
    pending.insert(pending.size(), w);
    recent_mv.insert(recent_mv.size(), mv);
    if (recent_mv.size() > 24) void'(recent_mv.pop_front());
  endtask

  task automatic add_face(logic [3:0] cnt, logic [11:0] a, b, c);
    word_t w;
    w = '{default: '0};
    w.fn = FN_FACE;
    w.cnt = cnt;
    w.ca = a;
    w.cb = b;
    w.cc = c;
    pending.insert(pending.size(), w);
  endtask

  function automatic logic [31:0] near_coord();
    if ($urandom_range(99) < 80) return 32'($urandom_range(8191)) - 32'd4096;
    return $urandom;
  endfunction

  function automatic logic [11:0] pick_mv();
    if (recent_mv.size() == 0 || $urandom_range(99) < 8) return 12'($urandom);
    return recent_mv[$urandom_range(recent_mv.size() - 1)];
  endfunction

  task automatic add_random(int n);
    word_t w;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 60) begin
        add_vertex(($urandom_range(99) < 90) ? 12'($urandom_range(255)) : 12'($urandom),
                   near_coord(), near_coord(), near_coord());
      end else if ($urandom_range(99) < 88) begin
        add_face(4'd3, pick_mv(), pick_mv(), pick_mv());
      end else begin
        w = '{default: '0};
        w.fn = FN_FACE;
        {w.mv, w.x, w.y, w.z} = 108'({$urandom, $urandom, $urandom, $urandom});
        w.cnt = 4'($urandom);
        w.ca = 12'($urandom);
        w.cb = 12'($urandom);
        w.cc = 12'($urandom);
        pending.insert(pending.size(), w);
      end
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_WELD_SCALE) weld_scale = data[31:0];
    else if (idx == CFG_MIN_AREA) min_area = data;
  endtask

  task automatic drain();
    do @(posedge clk); while (pending.size() != 0 || start || expected.size() != 0);
    repeat (200) @(posedge clk);
  endtask

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("mesh_vertex_weld_and_face_cull regression: fail");
    $finish;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) expected.insert(expected.size(), weld_predict(on_bus));
      if (pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
        on_bus = pending.pop_front();
        start <= 1'b1;
        func <= on_bus.fn;
        mesh_vertex <= on_bus.mv;
        coord_x <= on_bus.x;
        coord_y <= on_bus.y;
        coord_z <= on_bus.z;
        corner_count <= on_bus.cnt;
        corner_a <= on_bus.ca;
        corner_b <= on_bus.cb;
        corner_c <= on_bus.cc;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    weld_res_t e;
    if (!rst && done) begin
      if (expected.size() == 0) begin
        $display("%0t result word with nothing expected", $realtime);
        fails++;
      end else begin
        e = expected.pop_front();
        if (compact_index !== e.ci) report("compact_index", compact_index, e.ci);
        if (is_new !== e.nw) report("is_new", is_new, e.nw);
        if (table_full !== e.full) report("table_full", table_full, e.full);
        if (face_kept !== e.kept) report("face_kept", face_kept, e.kept);
        if (tri_a !== e.ta) report("tri_a", tri_a, e.ta);
        if (tri_b !== e.tb) report("tri_b", tri_b, e.tb);
        if (tri_c !== e.tc) report("tri_c", tri_c, e.tc);
        if (reject_reason !== e.rsn) report("reject_reason", reject_reason, e.rsn);
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    write_reg(CFG_SPARE, {16'hFFFF, 32'h0});
    write_reg(CFG_WELD_SCALE, 48'(WELD_SCALE_RST));
    write_reg(CFG_MIN_AREA, 48'd0);

    add_vertex(12'd0, 32'd0, 32'd0, 32'd0);
    add_vertex(12'd1, 32'd256, 32'd0, 32'd0);
    add_vertex(12'd2, 32'd0, 32'd256, 32'd0);
    add_vertex(12'd4095, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
    add_vertex(12'd3, 32'h80000000, 32'h7FFFFFFF, 32'd0);
    add_vertex(12'd5, 32'd100, 32'd0, 32'd0);
    add_vertex(12'd6, 32'd128, 32'd0, 32'd0);
    add_vertex(12'd8, -32'sd128, 32'd0, 32'd0);
    add_face(4'd3, 12'd0, 12'd1, 12'd2);
    add_face(4'd0, 12'd0, 12'd1, 12'd2);
    add_face(4'd15, 12'd0, 12'd1, 12'd2);
    add_face(4'd4, 12'd0, 12'd1, 12'd2);
    add_face(4'd3, 12'd0, 12'd1, 12'd7);
    add_face(4'd3, 12'd0, 12'd5, 12'd1);
    add_vertex(12'd7, 32'd512, 32'd0, 32'd0);
    add_face(4'd3, 12'd0, 12'd1, 12'd7);
    add_vertex(12'd1, 32'd0, 32'd0, 32'd256);
    add_face(4'd3, 12'd0, 12'd1, 12'd2);
    add_face(4'd3, 12'd4095, 12'd3, 12'd0);
    add_face(4'd3, 12'd4094, 12'd0, 12'd1);
    drain();

    write_reg(CFG_MIN_AREA, 48'd1);
    add_face(4'd3, 12'd0, 12'd6, 12'd7);
    add_face(4'd3, 12'd0, 12'd1, 12'd2);
    add_random(430);
    drain();

    idle_pct = 57;
    write_reg(CFG_WELD_SCALE, 48'd1);
    write_reg(CFG_MIN_AREA, 48'hFFFF_FFFF_FFFF);
    add_random(430);
    drain();

    idle_pct = 17;
    write_reg(CFG_WELD_SCALE, 48'hFFFF_FFFF);
    write_reg(CFG_MIN_AREA, 48'($urandom_range(1 << 26)));
    add_random(430);
    drain();

    idle_pct = 0;
    write_reg(CFG_WELD_SCALE, 48'($urandom_range(262144, 4096)));
    write_reg(CFG_MIN_AREA, 48'($urandom_range(1 << 22)));
    add_random(430);
    drain();

    if (fails == 0) begin
      $display("mesh_vertex_weld_and_face_cull regression: pass");
    end else begin
      $display("mesh_vertex_weld_and_face_cull regression: fail");
    end
    $finish;
  end

endmodule
